// ----- sv/pli_pkg.sv -----
package pli_pkg;

	// breakpoint table geometry
	localparam int TABLE_DEPTH = 64;
	localparam int AW = $clog2(TABLE_DEPTH);
	localparam int CW = 7;
	localparam int QUEUE_DEPTH = 2;

	// input word kinds carried on tuser
	localparam logic ACT_LOAD  = 1'b0;
	localparam logic ACT_QUERY = 1'b1;

	// result regions
	localparam logic [1:0] REG_BELOW  = 2'd0;
	localparam logic [1:0] REG_INSIDE = 2'd1;
	localparam logic [1:0] REG_ABOVE  = 2'd2;

	typedef struct packed {
		logic               action;
		logic [AW-1:0]      point_index;
		logic [15:0]        x_value;
		logic signed [15:0] y_value;
	} cmd_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_COUNT,
		ST_FETCH,
		ST_CALC,
		ST_DIV,
		ST_MUL,
		ST_ADD,
		ST_DONE
	} eng_state_t;

endpackage

// ----- sv/pli_front.sv -----
module pli_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s_axis_tvalid,
	output logic              s_axis_tready,
	input  logic [39:0]       s_axis_tdata,  // point_index, x_value, y_value, zero pad
	input  logic              s_axis_tuser,  // action
	output logic              cmd_valid,
	input  logic              cmd_ready,
	output pli_pkg::cmd_t     cmd
);

	logic          vld_q;
	pli_pkg::cmd_t cmd_q;

	assign s_axis_tready = !vld_q || cmd_ready;
	assign cmd_valid     = vld_q;
	assign cmd           = cmd_q;

	// input register: unpack the word into a command
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= 1'b0;
		end else if (s_axis_tready) begin
			vld_q <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_q.action      <= s_axis_tuser;
			cmd_q.point_index <= s_axis_tdata[pli_pkg::AW-1:0];
			cmd_q.x_value     <= s_axis_tdata[21:6];
			cmd_q.y_value     <= s_axis_tdata[37:22];
		end
	end

endmodule

// ----- sv/pli_queue.sv -----
module pli_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  pli_pkg::cmd_t in_cmd,
	output logic          out_valid,
	input  logic          out_ready,
	output pli_pkg::cmd_t out_cmd
);

	localparam int PW = $clog2(pli_pkg::QUEUE_DEPTH);

	pli_pkg::cmd_t mem_q [pli_pkg::QUEUE_DEPTH];
	logic [PW-1:0] wp_q, rp_q;
	logic [PW:0]   cnt_q;
	logic          push, pop;

	assign in_ready  = cnt_q != (PW+1)'(pli_pkg::QUEUE_DEPTH);
	assign out_valid = cnt_q != '0;
	assign out_cmd   = mem_q[rp_q];
	assign push      = in_valid && in_ready;
	assign pop       = out_valid && out_ready;

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= wp_q + PW'(1);
			if (pop)  rp_q <= rp_q + PW'(1);
			cnt_q <= cnt_q + (PW+1)'(push) - (PW+1)'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push) mem_q[wp_q] <= in_cmd;
	end

endmodule

// ----- sv/pli_engine.sv -----
module pli_engine (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic [pli_pkg::CW-1:0]       n_use,
	input  logic                         cmd_valid,
	output logic                         cmd_ready,
	input  pli_pkg::cmd_t                cmd,
	output logic                         res_valid,
	input  logic                         res_ready,
	output logic signed [15:0]           res_value,
	output logic [pli_pkg::CW-1:0]       res_index,
	output logic [1:0]                   res_region
);

	localparam int AW = pli_pkg::AW;
	localparam int CW = pli_pkg::CW;

	// breakpoint tables, two read ports
	logic [15:0]        bx_mem [pli_pkg::TABLE_DEPTH];
	logic signed [15:0] by_mem [pli_pkg::TABLE_DEPTH];
	logic [AW-1:0]      ra_addr, rb_addr;
	logic [15:0]        xa_q, xb_q;
	logic signed [15:0] ya_q, yb_q;
	logic               mem_we;

	pli_pkg::eng_state_t state_q, state_nx;

	logic [15:0]        xq_q;
	logic [CW-1:0]      n_q, iss_q, idx_q;
	logic               rv_q;
	logic [15:0]        den_q, rem_q, alpha_q;
	logic signed [15:0] y0_q, y1_q, res_q;
	logic [4:0]         step_q;
	logic signed [33:0] prod_q;
	logic [1:0]         region_q;
	logic               out_vld_q;
	logic               simple;
	logic [16:0]        rem_sh;
	logic signed [17:0] sum;

	assign mem_we    = state_q == pli_pkg::ST_IDLE && cmd_valid && cmd.action == pli_pkg::ACT_LOAD;
	assign cmd_ready = state_q == pli_pkg::ST_IDLE;
	assign res_valid  = out_vld_q;

	// read address choice
	always_comb begin
		ra_addr = iss_q[AW-1:0];
		rb_addr = idx_q[AW-1:0];
		if (state_q == pli_pkg::ST_FETCH) begin
			if (idx_q == '0)        ra_addr = '0;
			else if (idx_q >= n_q)  ra_addr = AW'(n_q - CW'(1));
			else                    ra_addr = AW'(idx_q - CW'(1));
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			bx_mem[cmd.point_index] <= cmd.x_value;
			by_mem[cmd.point_index] <= cmd.y_value;
		end
		xa_q <= bx_mem[ra_addr];
		ya_q <= by_mem[ra_addr];
		xb_q <= bx_mem[rb_addr];
		yb_q <= by_mem[rb_addr];
	end

	// segment is trivial when clamped or x is outside the open interval
	assign simple = idx_q == '0 || idx_q >= n_q || xq_q >= xb_q || xq_q <= xa_q || xb_q <= xa_q;
	assign rem_sh = {rem_q, 1'b0};
	assign sum    = 18'(y0_q) + prod_q[33:16];

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= pli_pkg::ST_IDLE;
		else         state_q <= state_nx;
	end

	always_comb begin
		state_nx = state_q;
		case (state_q)
			pli_pkg::ST_IDLE:
				if (cmd_valid && cmd.action == pli_pkg::ACT_QUERY) state_nx = pli_pkg::ST_COUNT;
			pli_pkg::ST_COUNT:
				if (iss_q == n_q && !rv_q) state_nx = pli_pkg::ST_FETCH;
			pli_pkg::ST_FETCH: state_nx = pli_pkg::ST_CALC;
			pli_pkg::ST_CALC:  state_nx = simple ? pli_pkg::ST_DONE : pli_pkg::ST_DIV;
			pli_pkg::ST_DIV:   if (step_q == 5'd15) state_nx = pli_pkg::ST_MUL;
			pli_pkg::ST_MUL:   state_nx = pli_pkg::ST_ADD;
			pli_pkg::ST_ADD:   state_nx = pli_pkg::ST_DONE;
			pli_pkg::ST_DONE:  if (!out_vld_q || res_ready) state_nx = pli_pkg::ST_IDLE;
			default:           state_nx = pli_pkg::ST_IDLE;
		endcase
	end

	// query datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			iss_q <= '0;
			idx_q <= '0;
			rv_q  <= 1'b0;
			n_q   <= CW'(pli_pkg::TABLE_DEPTH);
		end else begin
			case (state_q)
				pli_pkg::ST_IDLE: begin
					iss_q <= '0;
					idx_q <= '0;
					rv_q  <= 1'b0;
					if (n_use == '0)                                n_q <= CW'(1);
					else if (n_use > CW'(pli_pkg::TABLE_DEPTH))     n_q <= CW'(pli_pkg::TABLE_DEPTH);
					else                                            n_q <= n_use;
				end
				pli_pkg::ST_COUNT: begin
					rv_q <= iss_q < n_q;
					if (iss_q < n_q) iss_q <= iss_q + CW'(1);
					if (rv_q && xa_q <= xq_q) idx_q <= idx_q + CW'(1);
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			pli_pkg::ST_IDLE: xq_q <= cmd.x_value;
			pli_pkg::ST_CALC: begin
				y0_q    <= ya_q;
				y1_q    <= yb_q;
				den_q   <= xb_q - xa_q;
				rem_q   <= xq_q - xa_q;
				step_q  <= '0;
				if (idx_q == '0) region_q <= pli_pkg::REG_BELOW;
				else if (idx_q >= n_q) region_q <= pli_pkg::REG_ABOVE;
				else region_q <= pli_pkg::REG_INSIDE;
				if (idx_q != '0 && idx_q < n_q && xq_q >= xb_q) res_q <= yb_q;
				else res_q <= ya_q;
			end
			pli_pkg::ST_DIV: begin
				// restoring division, one quotient bit per cycle
				step_q <= step_q + 5'd1;
				if (rem_sh >= {1'b0, den_q}) begin
					rem_q   <= 16'(rem_sh - {1'b0, den_q});
					alpha_q <= {alpha_q[14:0], 1'b1};
				end else begin
					rem_q   <= rem_sh[15:0];
					alpha_q <= {alpha_q[14:0], 1'b0};
				end
			end
			pli_pkg::ST_MUL:
				prod_q <= (17'(y1_q) - 17'(y0_q)) * $signed({1'b0, alpha_q});
			pli_pkg::ST_ADD: res_q <= sum[15:0];
			default: ;
		endcase
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == pli_pkg::ST_DONE && (!out_vld_q || res_ready)) begin
			out_vld_q <= 1'b1;
		end else if (res_ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == pli_pkg::ST_DONE && (!out_vld_q || res_ready)) begin
			res_value  <= res_q;
			res_index  <= idx_q;
			res_region <= region_q;
		end
	end

	a_idx_bound: assert property (@(posedge clk) disable iff (!arst_n)
		idx_q <= iss_q && iss_q <= n_q) else $error("count beyond issued reads");
	a_div_rem: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pli_pkg::ST_DIV |-> rem_q < den_q) else $error("divider remainder too big");
	a_div_len: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pli_pkg::ST_MUL |-> $past(step_q) == 5'd15) else $error("short division");
	a_region: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == pli_pkg::ST_DONE |-> region_q != 2'd3) else $error("bad region");

endmodule

// ----- sv/piecewise_linear_interpolator.sv -----
// Clamped or degenerate segments skip the divider between acceptance and result.
// The engine counts breakpoints with one table read per cycle, so queries run one at a time.
// Reset clears the handshake state, queue and points_in_use (to 64); the table is not cleared.
module piecewise_linear_interpolator (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [6:0]  cfg_wdata,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [39:0] s_axis_tdata,  // point_index[5:0], x_value[21:6], y_value[37:22]
	input  logic        s_axis_tuser,  // action
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [31:0] m_axis_tdata   // result[15:0], segment_index[22:16], region[24:23]
);

	logic [6:0]         pts_q;
	logic               f_valid, f_ready, q_valid, q_ready;
	pli_pkg::cmd_t      f_cmd, q_cmd;
	logic signed [15:0] r_value;
	logic [6:0]         r_index;
	logic [1:0]         r_region;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     pts_q <= 7'(pli_pkg::TABLE_DEPTH);
		else if (cfg_we) pts_q <= cfg_wdata;
	end

	pli_front u_front (
		.clk, .arst_n, .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
		.cmd_valid(f_valid), .cmd_ready(f_ready), .cmd(f_cmd)
	);

	pli_queue u_queue (
		.clk, .arst_n, .in_valid(f_valid), .in_ready(f_ready), .in_cmd(f_cmd),
		.out_valid(q_valid), .out_ready(q_ready), .out_cmd(q_cmd)
	);

	pli_engine u_engine (
		.clk, .arst_n, .n_use(pts_q), .cmd_valid(q_valid), .cmd_ready(q_ready),
		.cmd(q_cmd), .res_valid(m_axis_tvalid), .res_ready(m_axis_tready),
		.res_value(r_value), .res_index(r_index), .res_region(r_region)
	);

	assign m_axis_tdata = {7'd0, r_region, r_index, r_value};

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

	localparam int LIMIT_CYCLES = 600000;
	localparam int SETTLE = 120;

	typedef struct {
		logic signed [15:0] result;
		logic [6:0]         segment_index;
		logic [1:0]         region;
	} interp_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [6:0]  cfg_wdata = '0;
	logic        s_axis_tvalid = 1'b0;
	logic        s_axis_tready;
	logic [39:0] s_axis_tdata = '0;  // point_index, x_value, y_value, pad
	logic        s_axis_tuser = 1'b0;  // action
	logic        m_axis_tvalid;
	logic        m_axis_tready = 1'b0;
	logic [31:0] m_axis_tdata;  // result, segment_index, region

	// shadow of the breakpoint table and the register
	logic [15:0]        shadow_x [pli_pkg::TABLE_DEPTH];
	logic signed [15:0] shadow_y [pli_pkg::TABLE_DEPTH];
	int unsigned        shadow_points = 64;

	interp_t pending_results[$];
	int unsigned send_gap_pct = 0, recv_stall_pct = 0;
	int unsigned cycles = 0, mismatches = 0, checked = 0, words_sent = 0;

	piecewise_linear_interpolator DUT (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata)
	);

	always #10 clk = ~clk;

	// watchdog
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > LIMIT_CYCLES) begin
			$display("timeout after %0d cycles", cycles);
			$display("*** FAILED ***");
			$finish;
		end
	end

	// receiver back-pressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= recv_stall_pct);
	end

	// expected interpolation for query abscissa xq
	function automatic interp_t interpolate(logic [15:0] xq);
		interp_t r;
		int n, cnt, x0, x1;
		longint alpha, prod;
		n = shadow_points < 1 ? 1 : (shadow_points > pli_pkg::TABLE_DEPTH ?
			pli_pkg::TABLE_DEPTH : shadow_points);
		cnt = 0;
		for (int i = 0; i < n; i++)
			if (shadow_x[i] <= xq) cnt++;
		r.segment_index = cnt[6:0];
		if (cnt == 0) begin
			r.result = shadow_y[0];
			r.region = pli_pkg::REG_BELOW;
		end else if (cnt >= n) begin
			r.result = shadow_y[n-1];
			r.region = pli_pkg::REG_ABOVE;
		end else begin
			x0 = shadow_x[cnt-1];
			x1 = shadow_x[cnt];
			r.region = pli_pkg::REG_INSIDE;
			if (xq >= x1)
				r.result = shadow_y[cnt];
			else if (xq <= x0 || x1 <= x0)
				r.result = shadow_y[cnt-1];
			else begin
				alpha = ((longint'(xq) - x0) <<< 16) / (x1 - x0);
				prod = (longint'(shadow_y[cnt]) - longint'(shadow_y[cnt-1])) * alpha;
				// arithmetic shift floors towards minus infinity
				r.result = 16'(longint'(shadow_y[cnt-1]) + (prod >>> 16));
			end
		end
		return r;
	endfunction

	// send one word; valid stays high so back-to-back words need no re-raise
	task automatic send_word(logic act, logic [5:0] idx, logic [15:0] xv, logic [15:0] yv);
		if ($urandom_range(99) < send_gap_pct) begin
			s_axis_tvalid <= 1'b0;
			do @(posedge clk); while ($urandom_range(99) < send_gap_pct);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= act;
		s_axis_tdata <= {2'b00, yv, xv, idx};
		@(negedge clk);
		while (!s_axis_tready) @(negedge clk);
		@(posedge clk);
		words_sent++;
		if (act == pli_pkg::ACT_LOAD) begin
			shadow_x[idx] = xv;
			shadow_y[idx] = yv;
		end else
			pending_results.push_back(interpolate(xv));
	endtask

	task automatic load_point(int idx, logic [15:0] xv, logic [15:0] yv);
		send_word(pli_pkg::ACT_LOAD, 6'(idx), xv, yv);
	endtask

	// ignored fields of a query carry random bits
	task automatic query(logic [15:0] xv);
		send_word(pli_pkg::ACT_QUERY, 6'($urandom), xv, 16'($urandom));
	endtask

	task automatic drain;
		s_axis_tvalid <= 1'b0;
		while (pending_results.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	// register written only with the block idle
	task automatic set_points(int unsigned v);
		drain();
		cfg_we <= 1'b1;
		cfg_wdata <= 7'(v);
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_points = v;
	endtask

	// strictly increasing active entries with random ordinates
	task automatic load_sorted_table;
		int unsigned step;
		int unsigned xs;
		int unsigned n;
		step = 1 + $urandom_range(1000);
		xs = $urandom_range(2000);
		n = shadow_points < 1 ? 1 : (shadow_points > pli_pkg::TABLE_DEPTH ?
			pli_pkg::TABLE_DEPTH : shadow_points);
		for (int i = 0; i < n; i++) begin
			load_point(i, 16'(xs), 16'($urandom));
			xs += 1 + $urandom_range(step);
		end
	endtask

	// result checker: a word is taken at the edge after a negedge with both high
	always @(negedge clk) begin
		interp_t got, want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			got.result = m_axis_tdata[15:0];
			got.segment_index = m_axis_tdata[22:16];
			got.region = m_axis_tdata[24:23];
			if (pending_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result word %h", m_axis_tdata);
			end else begin
				want = pending_results.pop_front();
				checked++;
				if (got.result !== want.result || got.segment_index !== want.segment_index
						|| got.region !== want.region) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp y=%0d seg=%0d reg=%0d, got y=%0d seg=%0d reg=%0d",
							want.result, want.segment_index, want.region,
							got.result, got.segment_index, got.region);
				end
			end
		end
	end

	// full table, extremes of abscissa and ordinate
	task automatic test_table_extremes;
		for (int i = 0; i < pli_pkg::TABLE_DEPTH - 1; i++)
			load_point(i, 16'(100 + i * 1000), 16'($urandom));
		load_point(pli_pkg::TABLE_DEPTH - 1, 16'hFFFF, 16'h7FFF);
		load_point(0, 16'd100, 16'h8000);
		load_point(1, 16'd1100, 16'h7FFF);
		query(16'd0);
		query(16'd100);
		query(16'd600);
		query(16'd1099);
		query(16'd1100);
		query(16'd62100);
		query(16'hFFFE);
		query(16'hFFFF);
		drain();
	endtask

	// one active breakpoint, and the register below its range
	task automatic test_single_point;
		set_points(1);
		query(16'd50);
		query(16'd100);
		query(16'hFFFF);
		set_points(0);
		query(16'd0);
		query(16'd5000);
		set_points(2);
		query(16'd700);
	endtask

	// descending and repeated abscissae
	task automatic test_unsorted;
		set_points(4);
		load_point(0, 16'd5000, 16'sd10);
		load_point(1, 16'd3000, -16'sd20);
		load_point(2, 16'd3000, 16'sd30);
		load_point(3, 16'd9000, 16'sd40);
		query(16'd2999);
		query(16'd3000);
		query(16'd4000);
		query(16'd6000);
		query(16'd9000);
		drain();
	endtask

	// register above the table depth
	task automatic test_register_high;
		set_points(127);
		query(16'($urandom));
		set_points(65);
		query(16'($urandom));
		set_points(64);
	endtask

	// sorted tables with random queries; some stray loads as noise
	task automatic test_random_phase(int unsigned gap_pct, int unsigned stall_pct, int items);
		int unsigned v;
		set_points($urandom_range(9) == 0 ? 64 : 1 + $urandom_range(63));
		send_gap_pct = gap_pct;
		recv_stall_pct = stall_pct;
		load_sorted_table();
		for (int k = 0; k < items; k++) begin
			v = $urandom_range(99);
			if (v < 8)
				load_point($urandom_range(63), 16'($urandom), 16'($urandom));
			else if (v < 12)
				query(16'($urandom_range(1)) ? 16'hFFFF : 16'h0000);
			else
				query(16'($urandom));
			if (k == items / 2) begin
				set_points(1 + $urandom_range(63));
				load_sorted_table();
			end
		end
		drain();
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_extremes();
		test_single_point();
		test_unsorted();
		test_register_high();
		test_random_phase(6, 80, 35);
		test_random_phase(80, 6, 35);
		test_random_phase(0, 0, 40);
		$display("sent %0d words, checked %0d query results, %0d mismatches",
			words_sent, checked, mismatches);
		$display("covered clamps, interpolation, unsorted tables and register range 0..127");
		if (mismatches == 0 && pending_results.size() == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end
endmodule

// ----- piecewise_linear_interpolator.f -----
sv/pli_pkg.sv
sv/pli_front.sv
sv/pli_queue.sv
sv/pli_engine.sv
sv/piecewise_linear_interpolator.sv
sim/tb.sv
